[sv/hics_pkg.sv]
// hics_pkg: shared constants, types and widths for the histogram inverse-cdf sampler
// used by histogram_inverse_cdf_sampler, hics_chk and the testbench; no dependencies
`default_nettype none

package hics_pkg;

  localparam int NUM_ZONES = 64;
  localparam int ZONE_AW   = (NUM_ZONES > 1) ? $clog2(NUM_ZONES) : 1;

  // field widths of the transaction payloads
  localparam int KIND_W  = 2;
  localparam int POS_W   = 32;
  localparam int RAND_W  = 16;
  localparam int ZONE_FW = 6;
  localparam int MAG_W   = 45;
  localparam int WID_W   = 31;
  localparam int IN_W    = 96;
  localparam int OUT_W   = 88;

  // internal widths
  localparam int BIN_W  = 40;
  localparam int CDF_W  = 17;
  localparam int TOT_W  = (BIN_W + ZONE_AW > MAG_W + 1) ? BIN_W + ZONE_AW : MAG_W + 1;
  localparam int REM_W  = TOT_W + 1;
  localparam int LIM_W  = POS_W + ZONE_AW;
  localparam int PROD_W = WID_W + RAND_W;
  localparam int SUM_W  = POS_W + ZONE_AW + 3;
  localparam int CNT_W  = 5;
  localparam int FRAC_STEPS = CDF_W;

  // apb
  localparam int ADDR_W = 3;
  localparam int DATA_W = 32;

  localparam logic [ZONE_AW-1:0] LAST_IDX  = ZONE_AW'(NUM_ZONES - 1);
  localparam logic [POS_W-1:0]   ORIGIN_RST = '0;
  localparam logic [WID_W-1:0]   ZONE_W_RST = WID_W'(65536);

  typedef enum logic [KIND_W-1:0] {
    KIND_SCORE  = 2'd0,
    KIND_BUILD  = 2'd1,
    KIND_SAMPLE = 2'd2,
    KIND_NONE   = 2'd3
  } kind_e;

  // register select is address bit 2
  typedef enum logic {
    REG_ORIGIN = 1'b0,
    REG_ZONE_W = 1'b1
  } reg_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SC_CHK,
    S_SC_DIV,
    S_SC_RD,
    S_SC_UPD,
    S_SC_TOT,
    S_BD_START,
    S_BD_RD,
    S_BD_ACC,
    S_BD_DIV,
    S_SP_RD,
    S_SP_CMP,
    S_SP_MUL1,
    S_SP_MUL2,
    S_SP_SUM,
    S_DONE
  } state_e;

endpackage

`default_nettype wire

[sv/histogram_inverse_cdf_sampler.sv]
// histogram_inverse_cdf_sampler: signed zone histogram, cdf build and inverse-cdf sampling
// depends on hics_pkg and hics_ram
//
//  channel   | dir | handshake             | payload
//  ----------+-----+-----------------------+---------------------------------------------
//  s_axis    | in  | tvalid/tready         | tuser kind; tdata position, amount, rands
//  m_axis    | out | tvalid/tready         | tdata zone, sample_position, flags, magnitude
//  apb       | in  | psel/penable/pwrite   | mesh_origin @0x0, zone_width @0x4
//
// one transaction at a time; s_axis_tready is high only while the sequencer is idle.
// score: the restoring divider finds the zone.
// build: the 17-step shared divider computes each cdf entry.
// sample: the one-port cdf search scans the zones, then the shared multiplier forms the position.
// after reset the bin and cdf stores read as zero through per-entry valid bits, no clear pass.
// a finished result sits in the output register; the next transaction is taken meanwhile.
`default_nettype none

module histogram_inverse_cdf_sampler
  import hics_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              s_axis_tvalid,
  output logic              s_axis_tready,
  // [31:0] position, [63:32] amount, [79:64] rand_zone, [95:80] rand_offset
  input  logic [IN_W-1:0]   s_axis_tdata,
  // [1:0] kind
  input  logic [KIND_W-1:0] s_axis_tuser,
  output logic              m_axis_tvalid,
  input  logic              m_axis_tready,
  // [5:0] zone, [37:6] sample_position, [38] negative_weight, [39] out_of_range,
  // [84:40] magnitude, [87:85] zero
  output logic [OUT_W-1:0]  m_axis_tdata,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready
);

  // configuration
  logic [POS_W-1:0] origin_q;
  logic [WID_W-1:0] zone_w_q;

  // latched transaction
  kind_e             kind_q, kind_d;
  logic [POS_W-1:0]  pos_q, pos_d;
  logic [POS_W-1:0]  amt_q, amt_d;
  logic [RAND_W-1:0] ru_q, ru_d;
  logic [RAND_W-1:0] ro_q, ro_d;

  // sequencer
  state_e             state_q, state_d;
  logic [ZONE_AW-1:0] idx_q, idx_d;
  logic [CNT_W-1:0]   cnt_q, cnt_d;
  logic [REM_W-1:0]   rem_q, rem_d;
  logic [CDF_W-1:0]   quo_q, quo_d;
  logic [TOT_W-1:0]   psum_q, psum_d;
  logic [TOT_W-1:0]   tot_q, tot_d;
  logic [BIN_W-1:0]   absn_q, absn_d;
  logic [SUM_W-1:0]   acc_q, acc_d;
  logic [PROD_W-1:0]  prod_q, prod_d;

  // result fields
  logic [ZONE_FW-1:0] res_zone_q, res_zone_d;
  logic [POS_W-1:0]   res_spos_q, res_spos_d;
  logic               res_neg_q, res_neg_d;
  logic               res_oor_q, res_oor_d;

  logic             m_tvalid_q, m_tvalid_d;
  logic [OUT_W-1:0] m_tdata_q, m_tdata_d;

  // stores and their valid bits
  logic [NUM_ZONES-1:0] bin_vld_q, bin_vld_d;
  logic [NUM_ZONES-1:0] cdf_vld_q, cdf_vld_d;
  logic                 bin_rvld_q, cdf_rvld_q;
  logic                 bin_we, cdf_we;
  logic [ZONE_AW-1:0]   bin_raddr, cdf_raddr;
  logic [BIN_W-1:0]     bin_wdata, bin_rdata;
  logic [CDF_W-1:0]     cdf_wdata, cdf_rdata;

  // shared subtract/compare unit and shared multiplier
  logic [REM_W-1:0]  sub_a, sub_b;
  logic [REM_W:0]    sub_res;
  logic              sub_ok;
  logic [RAND_W-1:0] mul_b;
  logic [PROD_W-1:0] mul_p;

  // datapath helpers
  logic [POS_W:0]        diff;
  logic [LIM_W-1:0]      limit;
  logic [BIN_W-1:0]      bin_old;
  logic [BIN_W-1:0]      abs_old;
  logic [BIN_W:0]        bin_sum;
  logic [BIN_W-1:0]      bin_new;
  logic [TOT_W-1:0]      psum_nxt;
  logic [CDF_W-1:0]      cdf_val;
  logic [SUM_W-1:0]      pos_sum;
  logic [MAG_W-1:0]      mag;
  logic                  s_acc;
  logic                  cfg_wr;

  assign s_acc  = s_axis_tvalid && s_axis_tready;
  assign cfg_wr = psel && penable && pwrite && pready;

  // apb port
  assign pready = 1'b1;
  assign prdata = (reg_e'(paddr[2]) == REG_ZONE_W) ? {1'b0, zone_w_q} : origin_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      origin_q <= ORIGIN_RST;
      zone_w_q <= ZONE_W_RST;
    end else if (cfg_wr) begin
      if (reg_e'(paddr[2]) == REG_ZONE_W) begin
        zone_w_q <= pwdata[WID_W-1:0];
      end else begin
        origin_q <= pwdata;
      end
    end
  end

  hics_ram #(.WIDTH(BIN_W), .DEPTH(NUM_ZONES)) u_bin_ram (
    .clk_i   (clk_i),
    .we_i    (bin_we),
    .waddr_i (idx_q),
    .wdata_i (bin_wdata),
    .raddr_i (bin_raddr),
    .rdata_o (bin_rdata)
  );

  hics_ram #(.WIDTH(CDF_W), .DEPTH(NUM_ZONES)) u_cdf_ram (
    .clk_i   (clk_i),
    .we_i    (cdf_we),
    .waddr_i (idx_q),
    .wdata_i (cdf_wdata),
    .raddr_i (cdf_raddr),
    .rdata_o (cdf_rdata)
  );

  // build divides the doubled remainder by the total, score divides by shifted zone width
  assign sub_a   = (state_q == S_BD_DIV && cnt_q != '0) ? {rem_q[REM_W-2:0], 1'b0} : rem_q;
  assign sub_b   = (state_q == S_BD_DIV) ? REM_W'(tot_q) : (REM_W'(zone_w_q) << cnt_q);
  assign sub_res = {1'b0, sub_a} - {1'b0, sub_b};
  assign sub_ok  = !sub_res[REM_W];

  assign mul_b = (state_q == S_SP_MUL1) ? ro_q : RAND_W'(idx_q);
  assign mul_p = PROD_W'(zone_w_q) * PROD_W'(mul_b);

  assign diff  = {pos_q[POS_W-1], pos_q} - {origin_q[POS_W-1], origin_q};
  assign limit = LIM_W'(zone_w_q) * LIM_W'(NUM_ZONES);

  assign bin_old  = bin_rvld_q ? bin_rdata : '0;
  assign abs_old  = bin_old[BIN_W-1] ? (~bin_old + BIN_W'(1)) : bin_old;
  assign bin_sum  = {bin_old[BIN_W-1], bin_old}
                  + {{(BIN_W + 1 - POS_W){amt_q[POS_W-1]}}, amt_q};
  // saturate to the signed 40-bit range
  assign bin_new  = (bin_sum[BIN_W] != bin_sum[BIN_W-1])
                  ? {bin_sum[BIN_W], {(BIN_W-1){~bin_sum[BIN_W]}}}
                  : bin_sum[BIN_W-1:0];
  assign psum_nxt = psum_q + TOT_W'(abs_old);
  assign cdf_val  = cdf_rvld_q ? cdf_rdata : '0;
  assign pos_sum  = acc_q + SUM_W'(prod_q);
  assign mag      = (|tot_q[TOT_W-1:MAG_W]) ? '1 : tot_q[MAG_W-1:0];

  assign bin_wdata = bin_new;
  assign cdf_wdata = {quo_q[CDF_W-2:0], sub_ok};

  always_comb begin
    state_d    = state_q;
    kind_d     = kind_q;
    pos_d      = pos_q;
    amt_d      = amt_q;
    ru_d       = ru_q;
    ro_d       = ro_q;
    idx_d      = idx_q;
    cnt_d      = cnt_q;
    rem_d      = rem_q;
    quo_d      = quo_q;
    psum_d     = psum_q;
    tot_d      = tot_q;
    absn_d     = absn_q;
    acc_d      = acc_q;
    prod_d     = prod_q;
    res_zone_d = res_zone_q;
    res_spos_d = res_spos_q;
    res_neg_d  = res_neg_q;
    res_oor_d  = res_oor_q;
    bin_vld_d  = bin_vld_q;
    cdf_vld_d  = cdf_vld_q;
    bin_we     = 1'b0;
    cdf_we     = 1'b0;
    bin_raddr  = idx_q;
    cdf_raddr  = idx_q;
    s_axis_tready = 1'b0;
    m_tvalid_d = m_tvalid_q && !m_axis_tready;
    m_tdata_d  = m_tdata_q;

    case (state_q)
      S_IDLE: begin
        s_axis_tready = 1'b1;
        if (s_axis_tvalid) begin
          kind_d     = kind_e'(s_axis_tuser);
          pos_d      = s_axis_tdata[31:0];
          amt_d      = s_axis_tdata[63:32];
          ru_d       = s_axis_tdata[79:64];
          ro_d       = s_axis_tdata[95:80];
          idx_d      = '0;
          res_zone_d = '0;
          res_spos_d = '0;
          res_neg_d  = 1'b0;
          res_oor_d  = 1'b0;
          case (kind_e'(s_axis_tuser))
            KIND_SCORE:  state_d = S_SC_CHK;
            KIND_BUILD:  state_d = S_BD_START;
            KIND_SAMPLE: state_d = S_SP_RD;
            default:     state_d = S_DONE;
          endcase
        end
      end

      S_SC_CHK: begin
        if (zone_w_q == '0 || diff[POS_W] || LIM_W'(diff[POS_W-1:0]) >= limit) begin
          res_oor_d = 1'b1;
          state_d   = S_DONE;
        end else begin
          rem_d   = REM_W'(diff[POS_W-1:0]);
          quo_d   = '0;
          cnt_d   = CNT_W'(ZONE_AW - 1);
          state_d = S_SC_DIV;
        end
      end

      S_SC_DIV: begin
        if (sub_ok) begin
          rem_d = sub_res[REM_W-1:0];
        end
        quo_d = {quo_q[CDF_W-2:0], sub_ok};
        if (cnt_q == '0) begin
          idx_d   = quo_d[ZONE_AW-1:0];
          state_d = S_SC_RD;
        end else begin
          cnt_d = cnt_q - CNT_W'(1);
        end
      end

      S_SC_RD: begin
        state_d = S_SC_UPD;
      end

      S_SC_UPD: begin
        bin_we           = 1'b1;
        bin_vld_d[idx_q] = 1'b1;
        tot_d   = tot_q - TOT_W'(abs_old);
        absn_d  = bin_new[BIN_W-1] ? (~bin_new + BIN_W'(1)) : bin_new;
        state_d = S_SC_TOT;
      end

      S_SC_TOT: begin
        tot_d      = tot_q + TOT_W'(absn_q);
        res_zone_d = ZONE_FW'(idx_q);
        state_d    = S_DONE;
      end

      S_BD_START: begin
        // an empty histogram keeps the previous cdf
        if (tot_q == '0) begin
          state_d = S_DONE;
        end else begin
          psum_d  = '0;
          idx_d   = '0;
          state_d = S_BD_RD;
        end
      end

      S_BD_RD: begin
        state_d = S_BD_ACC;
      end

      S_BD_ACC: begin
        psum_d  = psum_nxt;
        rem_d   = REM_W'(psum_nxt);
        quo_d   = '0;
        cnt_d   = '0;
        state_d = S_BD_DIV;
      end

      S_BD_DIV: begin
        rem_d = sub_ok ? sub_res[REM_W-1:0] : sub_a;
        quo_d = {quo_q[CDF_W-2:0], sub_ok};
        if (cnt_q == CNT_W'(FRAC_STEPS - 1)) begin
          cdf_we           = 1'b1;
          cdf_vld_d[idx_q] = 1'b1;
          if (idx_q == LAST_IDX) begin
            state_d = S_DONE;
          end else begin
            idx_d   = idx_q + ZONE_AW'(1);
            state_d = S_BD_RD;
          end
        end else begin
          cnt_d = cnt_q + CNT_W'(1);
        end
      end

      S_SP_RD: begin
        state_d = S_SP_CMP;
      end

      S_SP_CMP: begin
        // first zone whose cdf reaches the fraction, else the last zone
        if (CDF_W'(ru_q) <= cdf_val || idx_q == LAST_IDX) begin
          state_d = S_SP_MUL1;
        end else begin
          idx_d   = idx_q + ZONE_AW'(1);
          state_d = S_SP_RD;
        end
      end

      S_SP_MUL1: begin
        prod_d  = mul_p;
        state_d = S_SP_MUL2;
      end

      S_SP_MUL2: begin
        res_neg_d = bin_old[BIN_W-1] || (bin_old == '0);
        acc_d     = {{(SUM_W - POS_W){origin_q[POS_W-1]}}, origin_q}
                  + SUM_W'(prod_q[PROD_W-1:RAND_W]);
        prod_d    = mul_p;
        state_d   = S_SP_SUM;
      end

      S_SP_SUM: begin
        if (pos_sum[SUM_W-1:POS_W-1] != '0 && pos_sum[SUM_W-1:POS_W-1] != '1) begin
          res_spos_d = {pos_sum[SUM_W-1], {(POS_W-1){~pos_sum[SUM_W-1]}}};
        end else begin
          res_spos_d = pos_sum[POS_W-1:0];
        end
        res_zone_d = ZONE_FW'(idx_q);
        state_d    = S_DONE;
      end

      S_DONE: begin
        if (!m_tvalid_q || m_axis_tready) begin
          m_tvalid_d = 1'b1;
          m_tdata_d  = {3'b000, mag, res_oor_q, res_neg_q, res_spos_q, res_zone_q};
          state_d    = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      tot_q      <= '0;
      bin_vld_q  <= '0;
      cdf_vld_q  <= '0;
      bin_rvld_q <= 1'b0;
      cdf_rvld_q <= 1'b0;
      m_tvalid_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      tot_q      <= tot_d;
      bin_vld_q  <= bin_vld_d;
      cdf_vld_q  <= cdf_vld_d;
      bin_rvld_q <= bin_vld_q[bin_raddr];
      cdf_rvld_q <= cdf_vld_q[cdf_raddr];
      m_tvalid_q <= m_tvalid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    kind_q     <= kind_d;
    pos_q      <= pos_d;
    amt_q      <= amt_d;
    ru_q       <= ru_d;
    ro_q       <= ro_d;
    idx_q      <= idx_d;
    cnt_q      <= cnt_d;
    rem_q      <= rem_d;
    quo_q      <= quo_d;
    psum_q     <= psum_d;
    absn_q     <= absn_d;
    acc_q      <= acc_d;
    prod_q     <= prod_d;
    res_zone_q <= res_zone_d;
    res_spos_q <= res_spos_d;
    res_neg_q  <= res_neg_d;
    res_oor_q  <= res_oor_d;
    m_tdata_q  <= m_tdata_d;
  end

  assign m_axis_tvalid = m_tvalid_q;
  assign m_axis_tdata  = m_tdata_q;

endmodule

`default_nettype wire

[sv/hics_ram.sv]
// hics_ram: generic single-write, single-read ram with registered read data
// standalone, no package needed
`default_nettype none

module hics_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

`default_nettype wire

[sv/hics_chk.sv]
// hics_chk: port-level checker for histogram_inverse_cdf_sampler, bound to the top level
// depends on hics_pkg
`default_nettype none

module hics_chk
  import hics_pkg::*;
(
  input wire logic              clk_i,
  input wire logic              rst_ni,
  input wire logic              s_axis_tvalid,
  input wire logic              s_axis_tready,
  input wire logic              m_axis_tvalid,
  input wire logic              m_axis_tready,
  input wire logic [OUT_W-1:0]  m_axis_tdata,
  input wire logic              pready
);

  // a taken transaction keeps the block busy on the next cycle
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input taken again right after a transaction");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
    else $error("result changed while stalled");

  // out of range scores carry zone 0 and no sample fields
  a_oor_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[39] |-> m_axis_tdata[38:0] == '0)
    else $error("out of range result with nonzero zone or sample");

  a_pready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pready)
    else $error("apb pready low");

endmodule

bind histogram_inverse_cdf_sampler hics_chk u_hics_chk (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .pready        (pready)
);

`default_nettype wire

[tb/sv/tb.sv]
// tb: self-checking testbench for histogram_inverse_cdf_sampler (stream in, stream out, apb config)
// keeps its own histogram and cdf table to predict every result; needs hics_pkg and the rtl
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import hics_pkg::*;

  localparam longint BIN_HI  = 64'sd549755813887;
  localparam longint BIN_LO  = -64'sd549755813888;
  localparam longint MAG_TOP = 64'sd35184372088831;
  localparam longint POS_HI  = 64'sd2147483647;
  localparam longint POS_LO  = -64'sd2147483648;

  typedef struct packed {
    kind_e                   kind;
    logic signed [POS_W-1:0] position;
    logic signed [POS_W-1:0] amount;
    logic [RAND_W-1:0]       rand_zone;
    logic [RAND_W-1:0]       rand_offset;
    logic                    aim;   // pick rand_zone at or just above a cdf boundary when presented
    logic                    hold;  // wait for all outstanding results first
  } stim_t;

  typedef struct packed {
    logic [ZONE_FW-1:0] zone;
    logic [POS_W-1:0]   spos;
    logic               neg;
    logic               oor;
    logic [MAG_W-1:0]   mag;
  } outcome_t;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              s_axis_tvalid = 1'b0;
  logic              s_axis_tready;
  // [31:0] position, [63:32] amount, [79:64] rand_zone, [95:80] rand_offset
  logic [IN_W-1:0]   s_axis_tdata = '0;
  // [1:0] kind
  logic [KIND_W-1:0] s_axis_tuser = '0;
  logic              m_axis_tvalid;
  logic              m_axis_tready = 1'b0;
  // [5:0] zone, [37:6] sample_position, [38] negative_weight, [39] out_of_range,
  // [84:40] magnitude, [87:85] zero
  logic [OUT_W-1:0]  m_axis_tdata;
  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [ADDR_W-1:0] paddr = '0;
  logic [DATA_W-1:0] pwdata = '0;
  logic [DATA_W-1:0] prdata;
  logic              pready;

  histogram_inverse_cdf_sampler u_top (.*);

  always #5 clk_i = ~clk_i;

  // mirror of the block state
  logic signed [BIN_W-1:0] bin_q [NUM_ZONES] = '{default: '0};
  logic [CDF_W-1:0]        cdf_q [NUM_ZONES] = '{default: '0};
  logic signed [POS_W-1:0] origin_q = ORIGIN_RST;
  logic [WID_W-1:0]        width_q  = ZONE_W_RST;

  stim_t    item_backlog [$];
  outcome_t due_results [$];
  stim_t    drv_item;
  int       mismatch_count = 0;
  int       drv_wait = 0;
  int       mon_wait = 0;
  int       calm_left [2] = '{0, 0};
  bit       brisk = 1'b0;

  // side 0 is the sender, side 1 the receiver
  function automatic int draw_idle(int side);
    if (brisk) return 0;
    if (calm_left[side] > 0) begin
      calm_left[side]--;
      return 0;
    end
    if ($urandom_range(0, 24) == 0) calm_left[side] = $urandom_range(10, 40);
    return $urandom_range(0, 16);
  endfunction

  function automatic longint bin_abs(int idx);
    return (bin_q[idx] < 0) ? -longint'(bin_q[idx]) : longint'(bin_q[idx]);
  endfunction

  function automatic longint histogram_mass();
    longint sum;
    sum = 0;
    foreach (bin_q[i]) sum += bin_abs(i);
    return sum;
  endfunction

  function automatic void rebuild_cdf();
    longint total;
    longint run;
    total = histogram_mass();
    // an all-zero histogram keeps the previous table
    if (total == 0) return;
    run = 0;
    foreach (bin_q[i]) begin
      run += bin_abs(i);
      cdf_q[i] = CDF_W'((run <<< 16) / total);
    end
  endfunction

  function automatic outcome_t histogram_step(stim_t it);
    outcome_t r;
    longint   w;
    longint   diff;
    longint   v;
    longint   pos;
    longint   total;
    int       z;
    r = '0;
    w = longint'(width_q);
    case (it.kind)
      KIND_SCORE: begin
        diff = longint'(it.position) - longint'(origin_q);
        if (w == 0 || diff < 0 || diff >= w * NUM_ZONES) begin
          r.oor = 1'b1;
        end else begin
          z = int'(diff / w);
          v = longint'(bin_q[z]) + longint'(it.amount);
          if (v > BIN_HI) v = BIN_HI;
          else if (v < BIN_LO) v = BIN_LO;
          bin_q[z] = BIN_W'(v);
          r.zone = ZONE_FW'(z);
        end
      end
      KIND_BUILD: rebuild_cdf();
      KIND_SAMPLE: begin
        z = NUM_ZONES - 1;
        for (int i = NUM_ZONES - 1; i >= 0; i--) if (it.rand_zone <= cdf_q[i]) z = i;
        pos = longint'(origin_q) + longint'(z) * w
            + ((w * longint'(it.rand_offset)) >>> 16);
        if (pos > POS_HI) pos = POS_HI;
        else if (pos < POS_LO) pos = POS_LO;
        r.spos = POS_W'(pos);
        r.neg  = (bin_q[z] <= 0);
        r.zone = ZONE_FW'(z);
      end
      default: ;
    endcase
    total = histogram_mass();
    r.mag = (total > MAG_TOP) ? MAG_W'(MAG_TOP) : MAG_W'(total);
    return r;
  endfunction

  function automatic void check_outcome(logic [OUT_W-1:0] data);
    outcome_t want;
    outcome_t got;
    got.zone = data[5:0];
    got.spos = data[37:6];
    got.neg  = data[38];
    got.oor  = data[39];
    got.mag  = data[84:40];
    if (due_results.size() == 0) begin
      mismatch_count++;
      if (mismatch_count <= 10) $display("result transaction with none pending: %h", data);
      return;
    end
    want = due_results.pop_front();
    if (got.zone != want.zone || got.spos != want.spos || got.neg != want.neg ||
        got.oor != want.oor || got.mag != want.mag || data[OUT_W-1:85] != '0) begin
      mismatch_count++;
      if (mismatch_count <= 10)
        $display("mismatch exp/got: zone %0d/%0d pos %h/%h neg %b/%b oor %b/%b mag %h/%h pad %b",
                 want.zone, got.zone, want.spos, got.spos, want.neg, got.neg,
                 want.oor, got.oor, want.mag, got.mag, data[OUT_W-1:85]);
    end
  endfunction

  function automatic stim_t random_item();
    stim_t  it;
    longint w;
    longint p;
    int     roll;
    w = longint'(width_q);
    it.kind        = KIND_NONE;
    it.position    = $urandom;
    it.amount      = $urandom;
    it.rand_zone   = RAND_W'($urandom);
    it.rand_offset = RAND_W'($urandom);
    it.aim         = 1'b0;
    it.hold        = ($urandom_range(0, 39) == 0);
    roll = $urandom_range(0, 99);
    if (roll < 52) begin
      it.kind = KIND_SCORE;
      p = longint'(origin_q) + longint'($urandom_range(0, NUM_ZONES - 1)) * w;
      if (w > 0) p += longint'($urandom_range(0, 32'(w - 1)));
      case ($urandom_range(0, 9))
        0: p = longint'(it.position);
        1: p = $urandom_range(0, 1) ? longint'(origin_q) - 1 : longint'(origin_q) + w * NUM_ZONES;
        default: ;
      endcase
      it.position = (p > POS_HI || p < POS_LO) ? origin_q : POS_W'(p);
      case ($urandom_range(0, 7))
        0: it.amount = 32'h7FFF_FFFF;
        1: it.amount = 32'h8000_0000;
        2, 3: ;
        default: it.amount = 32'($urandom_range(0, 1 << 21)) - 32'(1 << 20);
      endcase
    end else if (roll < 60) begin
      it.kind = KIND_BUILD;
    end else if (roll < 97) begin
      it.kind = KIND_SAMPLE;
      case ($urandom_range(0, 7))
        0: it.rand_zone = '0;
        1: it.rand_zone = '1;
        2, 3: it.aim = 1'b1;
        default: ;
      endcase
      case ($urandom_range(0, 5))
        0: it.rand_offset = '0;
        1: it.rand_offset = '1;
        default: ;
      endcase
    end
    return it;
  endfunction

  task automatic queue_req(input kind_e kind, input logic [POS_W-1:0] position,
                           input logic [POS_W-1:0] amount, input logic [RAND_W-1:0] rz,
                           input logic [RAND_W-1:0] ro);
    stim_t it;
    it = '0;
    it.kind        = kind;
    it.position    = position;
    it.amount      = amount;
    it.rand_zone   = rz;
    it.rand_offset = ro;
    item_backlog.push_back(it);
  endtask

  task automatic reg_write(input reg_e which, input logic [DATA_W-1:0] value);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ADDR_W'({which, 2'b00});
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (which == REG_ORIGIN) origin_q = value;
    else width_q = value[WID_W-1:0];
  endtask

  // sampled on the falling edge so that the rising-edge updates have settled
  task automatic wait_for_quiet();
    do @(negedge clk_i);
    while (item_backlog.size() != 0 || s_axis_tvalid || due_results.size() != 0);
  endtask

  task automatic run_phase(input logic [DATA_W-1:0] origin, input logic [DATA_W-1:0] width,
                           input int count);
    reg_write(REG_ORIGIN, origin);
    reg_write(REG_ZONE_W, width);
    repeat (count) item_backlog.push_back(random_item());
    wait_for_quiet();
  endtask

  // sender
  always @(posedge clk_i) begin : feed
    logic vld;
    int   t;
    int   k;
    vld = s_axis_tvalid;
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) begin
        due_results.push_back(histogram_step(drv_item));
        vld = 1'b0;
        drv_wait = draw_idle(0);
      end
      if (!vld) begin
        if (drv_wait > 0) begin
          drv_wait--;
        end else if (item_backlog.size() != 0 &&
                     !(item_backlog[0].hold && due_results.size() != 0)) begin
          drv_item = item_backlog.pop_front();
          if (drv_item.aim) begin
            k = $urandom_range(0, NUM_ZONES - 1);
            t = int'(cdf_q[k]) + int'($urandom_range(0, 1));
            drv_item.rand_zone = (t > 65535) ? '1 : RAND_W'(t);
          end
          vld = 1'b1;
          s_axis_tuser <= drv_item.kind;
          s_axis_tdata <= {drv_item.rand_offset, drv_item.rand_zone,
                           drv_item.amount, drv_item.position};
        end
      end
    end
    s_axis_tvalid <= vld;
  end

  // receiver
  always @(posedge clk_i) begin : sink
    logic rdy;
    rdy = m_axis_tready;
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        check_outcome(m_axis_tdata);
        mon_wait = draw_idle(1);
      end
      if (mon_wait > 0) begin
        mon_wait--;
        rdy = 1'b0;
      end else begin
        rdy = 1'b1;
      end
    end
    m_axis_tready <= rdy;
  end

  initial begin : stimulus
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    // reset mesh: origin 0, zones of 1.0, mesh ends at 0x40_0000
    queue_req(KIND_NONE, '1, '1, '1, '1);
    queue_req(KIND_BUILD, '0, '0, '0, '0);       // empty histogram, table stays zero
    queue_req(KIND_SAMPLE, '0, '0, 16'h0000, 16'hFFFF);
    queue_req(KIND_SAMPLE, '0, '0, 16'hFFFF, 16'h0000);  // nothing reaches it, last zone
    queue_req(KIND_SCORE, 32'hFFFF_FFFF, 32'h7FFF_FFFF, '0, '0);
    queue_req(KIND_SCORE, 32'h0040_0000, 32'h7FFF_FFFF, '0, '0);
    queue_req(KIND_SCORE, 32'h7FFF_FFFF, 32'h0000_0001, '0, '0);
    queue_req(KIND_SCORE, 32'h8000_0000, 32'h0000_0001, '0, '0);
    queue_req(KIND_SCORE, 32'h0000_0000, 32'h7FFF_FFFF, '0, '0);
    queue_req(KIND_SCORE, 32'h003F_FFFF, 32'h8000_0000, '0, '0);
    queue_req(KIND_SCORE, 32'h0003_0005, 32'd1000, '0, '0);
    queue_req(KIND_BUILD, '0, '0, '0, '0);
    queue_req(KIND_SAMPLE, '0, '0, 16'h0000, 16'h0000);
    queue_req(KIND_SAMPLE, '0, '0, 16'hFFFF, 16'hFFFF);
    queue_req(KIND_SAMPLE, '0, '0, 16'h4000, 16'h8000);
    // cancel every bin so the next build sees a zero sum
    queue_req(KIND_SCORE, 32'h0003_0005, 32'hFFFF_FC18, '0, '0);
    queue_req(KIND_SCORE, 32'h0000_0000, 32'h8000_0001, '0, '0);
    queue_req(KIND_SCORE, 32'h003F_0000, 32'h4000_0000, '0, '0);
    queue_req(KIND_SCORE, 32'h003F_0000, 32'h4000_0000, '0, '0);
    queue_req(KIND_BUILD, '0, '0, '0, '0);
    queue_req(KIND_SAMPLE, '0, '0, 16'h8000, 16'h0001);
    queue_req(KIND_SAMPLE, '0, '0, 16'h0001, 16'hFFFF);
    queue_req(KIND_SCORE, 32'h000A_0000, 32'h0000_0000, '0, '0);
    queue_req(KIND_NONE, '0, '0, '0, '0);
    wait_for_quiet();

    // every bin is zero here: drive one bin into the top clamp, its neighbor into the bottom one
    brisk = 1'b1;
    repeat (258) queue_req(KIND_SCORE, 32'h0005_0000, 32'h7FFF_FFFF, '0, '0);
    repeat (258) queue_req(KIND_SCORE, 32'h0006_0000, 32'h8000_0000, '0, '0);
    queue_req(KIND_BUILD, '0, '0, '0, '0);
    repeat (6) queue_req(KIND_SAMPLE, '0, '0, RAND_W'($urandom), RAND_W'($urandom));
    wait_for_quiet();
    brisk = 1'b0;

    run_phase(32'h8000_0000, 32'h0000_0001, 20);
    run_phase(32'h7FFF_FFFF, 32'h7FFF_FFFF, 15);
    run_phase(32'h8000_0000, 32'h7FFF_FFFF, 15);
    run_phase($urandom, 32'($urandom_range(1, 1 << 26)), 20);
    run_phase($urandom, 32'h8000_0000, 15);      // width field reads as zero
    run_phase(-32'($urandom_range(0, 1 << 22)), 32'($urandom_range(256, 1 << 18)), 25);

    // longer than a full build, so a stray late result still lands in the run
    repeat (1300) @(posedge clk_i);
    if (mismatch_count == 0 && due_results.size() == 0)
      $display("histogram_inverse_cdf_sampler regression: pass");
    else
      $display("histogram_inverse_cdf_sampler regression: fail");
    $finish;
  end

  initial begin : watchdog
    #80_000_000;
    $display("histogram_inverse_cdf_sampler regression: fail");
    $finish;
  end

endmodule

[sim.f]
sv/hics_pkg.sv
sv/hics_ram.sv
sv/histogram_inverse_cdf_sampler.sv
sv/hics_chk.sv
tb/sv/tb.sv
